>>> src/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Shared constants, result codes, text helpers and the verdict snapshot type.
// ----------------------------------------------------------------------------
package hrhp_pkg;

   // Bytes past BUFFER_CAP (65535) are ignored; only their last flag counts.
   localparam int MAX_BUFFER_BYTES = 65536;
   localparam int BUFFER_CAP_INT   = (MAX_BUFFER_BYTES < 65535) ? MAX_BUFFER_BYTES : 65535;
   localparam int POS_W            = 16;
   localparam logic [POS_W-1:0] BUFFER_CAP = POS_W'(BUFFER_CAP_INT);

   // Default width of the decimal length accumulator.
   localparam int DEFAULT_LENGTH_BITS = 32;

   // Result codes.
   localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED  = 2'd1;
   localparam logic [1:0] STATUS_COMPLETE   = 2'd2;

   localparam logic [1:0] ROUTE_OTHER = 2'd0;
   localparam logic [1:0] ROUTE_READY = 2'd1;
   localparam logic [1:0] ROUTE_FRAUD = 2'd2;

   // Fixed texts, right aligned in a wide vector.
   localparam int TEXT_W = 256;
   localparam logic [TEXT_W-1:0] GET_LINE     = TEXT_W'("GET /ready HTTP/1.1");
   localparam int                GET_LEN      = 19;
   localparam logic [TEXT_W-1:0] POST_LINE    = TEXT_W'("POST /fraud-score HTTP/1.1");
   localparam int                POST_LEN     = 26;
   localparam logic [TEXT_W-1:0] VERSION_TAG  = TEXT_W'("HTTP/1.1");
   localparam int                VERSION_LEN  = 8;
   localparam logic [TEXT_W-1:0] CL_NAME      = TEXT_W'("content-length:");
   localparam int                CL_LEN       = 15;
   localparam logic [TEXT_W-1:0] CONN_NAME    = TEXT_W'("connection:");
   localparam int                CONN_LEN     = 11;
   localparam logic [TEXT_W-1:0] CLOSE_WORD   = TEXT_W'("close");
   localparam int                CLOSE_LEN    = 5;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // Everything the verdict stage needs, captured on the last byte of a buffer.
   typedef struct packed {
      logic             body_phase;
      logic             error;
      logic [1:0]       route;
      logic             persist;
      logic [POS_W-1:0] body_start;
      logic [POS_W-1:0] byte_count;
   } verdict_snap_type;

   // Character at position idx of a right-aligned text of length len.
   function automatic logic [7:0] hrhp_text_char(input logic [TEXT_W-1:0] text,
                                                 input int len,
                                                 input logic [4:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (int'(idx) < len) begin
         ch = text[8*(len-1-int'(idx)) +: 8];
      end
      return ch;
   endfunction

endpackage

>>> src/hrhp_req_if.sv
// ----------------------------------------------------------------------------
// Request byte channel
// Valid/ready channel carrying one buffer byte and its last flag per word.
// ----------------------------------------------------------------------------
interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> src/hrhp_rsp_if.sv
// ----------------------------------------------------------------------------
// Verdict channel
// Valid/ready channel carrying one parse verdict per word.
// ----------------------------------------------------------------------------
interface hrhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [1:0]  route;
   logic        conn_persist;
   logic [31:0] body_bytes;
   logic [15:0] body_offset;
   logic [32:0] need_bytes;

   modport source (output valid, output status, output route, output conn_persist,
                   output body_bytes, output body_offset, output need_bytes,
                   input ready);
   modport sink   (input valid, input status, input route, input conn_persist,
                   input body_bytes, input body_offset, input need_bytes,
                   output ready);
endinterface

>>> src/http_request_header_parser_top.sv
// ----------------------------------------------------------------------------
// HTTP request header parser, top level
// Verdicts pass the snapshot register, then the output register that drives valid.
// Throughput: one buffer byte per cycle when not stalled (single-pass state update).
// The request side stalls only while both verdict stages are full and rsp_chan waits.
// Reset is synchronous and active high; it clears the parser and both verdict stages.
// The parser state also returns to its reset values after every last byte.
// ----------------------------------------------------------------------------
//
// Structure
//   hrhp_parser  - per-byte state machine. Each accepted word updates the line
//                  scanner, the request line matcher, the header name matcher
//                  and the Content-Length / Connection value machines. A CR is
//                  held back one byte so that CR LF can end a line; a CR that
//                  is not followed by LF is then fed as content ahead of the
//                  current byte.
//   hrhp_verdict - takes a snapshot of the parse on the last word, forms the
//                  status and the lengths from it and keeps the result word in
//                  the output register.
//
// The snapshot register acts as a skid stage between the two sides: the
// parser keeps taking bytes of the next buffer while a verdict waits to be
// taken. Bytes beyond the buffer limit in the package are ignored, but their
// last flag still produces a verdict on the truncated buffer.
module http_request_header_parser_top
   import hrhp_pkg::*;
#(
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input logic        clock,
   input logic        reset,
   hrhp_req_if.sink   req_chan,
   hrhp_rsp_if.source rsp_chan
);

   logic                   snap_free;
   logic                   snap_load;
   verdict_snap_type       snap;
   logic [LENGTH_BITS-1:0] snap_length;

   // Byte-level parsing of the request line and header lines.
   hrhp_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .snap_free   (snap_free),
      .snap_load   (snap_load),
      .snap        (snap),
      .snap_length (snap_length)
   );

   // Verdict formation and the result register.
   hrhp_verdict #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_verdict (
      .clock       (clock),
      .reset       (reset),
      .snap_load   (snap_load),
      .snap        (snap),
      .snap_length (snap_length),
      .snap_free   (snap_free),
      .rsp_chan    (rsp_chan)
   );

endmodule

>>> src/hrhp_parser.sv
// ----------------------------------------------------------------------------
// HTTP request header parser: byte state machine
// Updates the line and header state for each accepted byte and hands a
// snapshot of the parse to the verdict stage on the last byte.
// ----------------------------------------------------------------------------
module hrhp_parser
   import hrhp_pkg::*;
#(
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   hrhp_req_if.sink               req_chan,
   input  logic                   snap_free,
   output logic                   snap_load,
   output verdict_snap_type       snap,
   output logic [LENGTH_BITS-1:0] snap_length
);

   typedef enum logic [1:0] {PH_REQUEST, PH_HEADER, PH_BODY} phase_type;

   localparam int GW = LENGTH_BITS + 4;

   localparam logic [2:0] LEN_IDLE   = 3'd0;
   localparam logic [2:0] LEN_DIGITS = 3'd1;
   localparam logic [2:0] LEN_BAD    = 3'd2;
   localparam logic [2:0] CONN_IDLE  = 3'd0;
   localparam logic [2:0] CONN_DONE  = 3'd5;
   localparam logic [2:0] CONN_BAD   = 3'd6;

   localparam logic [3:0] TAIL_DONE   = 4'd8;
   localparam logic [3:0] TAIL_FAILED = 4'd15;
   localparam logic [4:0] LINE_SAT    = 5'd31;

   typedef struct packed {
      logic [4:0]             line_pos;
      logic                   get_alive;
      logic                   post_alive;
      logic [1:0]             spaces;
      logic [3:0]             tail;
      logic                   cl_alive;
      logic                   conn_alive;
      logic                   in_len;
      logic                   in_conn;
      logic [2:0]             sub;
      logic [LENGTH_BITS-1:0] acc;
   } feed_state_type;

   // One content byte of a line, request line or header line.
   function automatic feed_state_type feed_byte(input feed_state_type s,
                                                input logic is_request,
                                                input logic [7:0] c);
      feed_state_type n;
      logic [7:0]     lc;
      logic           digit;
      logic           blank;
      logic [GW-1:0]  grown;
      n     = s;
      lc    = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
      digit = (c >= "0") && (c <= "9");
      blank = (c == CH_SPACE) || (c == CH_TAB);
      grown = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + GW'(c[3:0]);
      if (is_request) begin
         if (s.line_pos >= 5'(GET_LEN) || c != hrhp_text_char(GET_LINE, GET_LEN, s.line_pos))
            n.get_alive = 1'b0;
         if (s.line_pos >= 5'(POST_LEN) ||
             c != hrhp_text_char(POST_LINE, POST_LEN, s.line_pos))
            n.post_alive = 1'b0;
         if (c == CH_SPACE) begin
            if (s.spaces != 2'd3) n.spaces = s.spaces + 2'd1;
            if (n.spaces == 2'd2) n.tail = 4'd0;
         end else if (s.spaces == 2'd2) begin
            n.tail = (s.tail < TAIL_DONE &&
                      c == hrhp_text_char(VERSION_TAG, VERSION_LEN, 5'(s.tail)))
                     ? s.tail + 4'd1 : TAIL_FAILED;
         end
      end else if (s.in_len) begin
         case (s.sub)
            LEN_IDLE: begin
               if (!blank) begin
                  if (digit) begin
                     n.acc = LENGTH_BITS'(c[3:0]);
                     n.sub = LEN_DIGITS;
                  end else begin
                     n.sub = LEN_BAD;
                  end
               end
            end
            LEN_DIGITS: begin
               // The value may not pass 2^LENGTH_BITS - 1.
               if (!digit || grown[GW-1:LENGTH_BITS] != 4'd0) n.sub = LEN_BAD;
               else n.acc = grown[LENGTH_BITS-1:0];
            end
            default: n.sub = s.sub;
         endcase
      end else if (s.in_conn) begin
         if (s.sub == CONN_IDLE) begin
            if (!blank) n.sub = (lc == "c") ? 3'd1 : CONN_BAD;
         end else if (s.sub >= 3'd1 && s.sub <= 3'd4) begin
            n.sub = (lc == hrhp_text_char(CLOSE_WORD, CLOSE_LEN, 5'(s.sub)))
                    ? s.sub + 3'd1 : CONN_BAD;
         end else begin
            n.sub = CONN_BAD;
         end
      end else begin
         if (s.cl_alive && !(s.line_pos < 5'(CL_LEN) &&
                             lc == hrhp_text_char(CL_NAME, CL_LEN, s.line_pos)))
            n.cl_alive = 1'b0;
         if (s.conn_alive && !(s.line_pos < 5'(CONN_LEN) &&
                               lc == hrhp_text_char(CONN_NAME, CONN_LEN, s.line_pos)))
            n.conn_alive = 1'b0;
         if (n.cl_alive && s.line_pos == 5'(CL_LEN - 1)) begin
            n.cl_alive   = 1'b0;
            n.conn_alive = 1'b0;
            n.in_len     = 1'b1;
         end else if (n.conn_alive && s.line_pos == 5'(CONN_LEN - 1)) begin
            n.cl_alive   = 1'b0;
            n.conn_alive = 1'b0;
            n.in_conn    = 1'b1;
         end
      end
      if (s.line_pos != LINE_SAT) n.line_pos = s.line_pos + 5'd1;
      return n;
   endfunction

   function automatic feed_state_type start_line(input feed_state_type s);
      feed_state_type n;
      n            = s;
      n.line_pos   = 5'd0;
      n.cl_alive   = 1'b1;
      n.conn_alive = 1'b1;
      n.in_len     = 1'b0;
      n.in_conn    = 1'b0;
      n.sub        = 3'd0;
      n.acc        = '0;
      return n;
   endfunction

   phase_type              phase_ff, phase_in;
   feed_state_type         fs_ff, fs_in, fs_reset;
   logic [POS_W-1:0]       byte_pos_ff, byte_pos_in;
   logic                   prev_cr_ff, prev_cr_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic                   persist_ff, persist_in;
   logic                   error_ff, error_in;
   logic [1:0]             route_ff, route_in;
   logic                   seen_ff, seen_in;
   logic [POS_W-1:0]       body_start_ff, body_start_in;
   logic                   accept;
   logic                   is_request;
   feed_state_type         fed;
   logic [7:0]             c;

   assign req_chan.ready = snap_free;
   assign accept         = req_chan.valid && snap_free;
   assign c              = req_chan.data_byte;
   assign is_request     = (phase_ff == PH_REQUEST);

   always_comb begin
      fs_reset            = start_line('0);
      fs_reset.get_alive  = 1'b1;
      fs_reset.post_alive = 1'b1;
   end

   always_comb begin
      phase_in      = phase_ff;
      fs_in         = fs_ff;
      byte_pos_in   = byte_pos_ff;
      prev_cr_in    = prev_cr_ff;
      length_in     = length_ff;
      persist_in    = persist_ff;
      error_in      = error_ff;
      route_in      = route_ff;
      seen_in       = seen_ff;
      body_start_in = body_start_ff;
      fed           = fs_ff;
      if (accept && byte_pos_ff < BUFFER_CAP) begin
         if (phase_ff != PH_BODY) begin
            if (prev_cr_ff && c == CH_LF) begin
               if (phase_ff == PH_REQUEST) begin
                  if (fs_ff.get_alive && fs_ff.line_pos == 5'(GET_LEN))
                     route_in = ROUTE_READY;
                  else if (fs_ff.post_alive && fs_ff.line_pos == 5'(POST_LEN))
                     route_in = ROUTE_FRAUD;
                  else if (fs_ff.spaces == 2'd2 && fs_ff.tail == TAIL_DONE)
                     route_in = ROUTE_OTHER;
                  else
                     error_in = 1'b1;
                  phase_in = PH_HEADER;
                  fs_in    = start_line(fs_ff);
               end else if (fs_ff.line_pos == 5'd0) begin
                  // Blank line ends the header; a request with no header lines is bad.
                  if (!seen_ff) error_in = 1'b1;
                  body_start_in = byte_pos_ff + 16'd1;
                  phase_in      = PH_BODY;
               end else begin
                  if (fs_ff.in_len) begin
                     if (fs_ff.sub == LEN_BAD) error_in = 1'b1;
                     else length_in = fs_ff.acc;
                  end else if (fs_ff.in_conn) begin
                     if (fs_ff.sub == CONN_DONE) persist_in = 1'b0;
                  end
                  seen_in = 1'b1;
                  fs_in   = start_line(fs_ff);
               end
            end else begin
               // A CR held back from the previous byte turns out to be content.
               if (prev_cr_ff) fed = feed_byte(fed, is_request, CH_CR);
               if (c != CH_CR) fed = feed_byte(fed, is_request, c);
               fs_in = fed;
            end
         end
         prev_cr_in  = (c == CH_CR);
         byte_pos_in = byte_pos_ff + 16'd1;
      end
   end

   assign snap_load             = accept && req_chan.last_byte;
   assign snap.body_phase       = (phase_in == PH_BODY);
   assign snap.error            = error_in;
   assign snap.route            = route_in;
   assign snap.persist          = persist_in;
   assign snap.body_start       = body_start_in;
   assign snap.byte_count       = byte_pos_in;
   assign snap_length           = length_in;

   always_ff @(posedge clock) begin
      if (reset || snap_load) begin
         phase_ff      <= PH_REQUEST;
         fs_ff         <= fs_reset;
         byte_pos_ff   <= '0;
         prev_cr_ff    <= 1'b0;
         length_ff     <= '0;
         persist_ff    <= 1'b1;
         error_ff      <= 1'b0;
         route_ff      <= ROUTE_OTHER;
         seen_ff       <= 1'b0;
         body_start_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         fs_ff         <= fs_in;
         byte_pos_ff   <= byte_pos_in;
         prev_cr_ff    <= prev_cr_in;
         length_ff     <= length_in;
         persist_ff    <= persist_in;
         error_ff      <= error_in;
         route_ff      <= route_in;
         seen_ff       <= seen_in;
         body_start_ff <= body_start_in;
      end
   end

   // The body offset is only known once the blank line has been seen.
   a_body_start_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_BODY |-> body_start_ff == '0)
      else $error("body start set before the blank line");

   // A clean entry into the body needs at least one header line.
   a_body_needs_header: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY && !error_ff) |-> seen_ff)
      else $error("body reached without header lines and without error");

endmodule

>>> src/hrhp_verdict.sv
// ----------------------------------------------------------------------------
// HTTP request header parser: verdict stage
// Holds the snapshot of a finished buffer, forms the result word and keeps
// it in the output register until it is taken.
// ----------------------------------------------------------------------------
module hrhp_verdict
   import hrhp_pkg::*;
#(
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   snap_load,
   input  verdict_snap_type       snap,
   input  logic [LENGTH_BITS-1:0] snap_length,
   output logic                   snap_free,
   hrhp_rsp_if.source             rsp_chan
);

   localparam int SUM_W = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 1;

   logic                   snap_valid_ff, snap_valid_in;
   verdict_snap_type       snap_ff;
   logic [LENGTH_BITS-1:0] snap_length_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [1:0]             out_status_ff, out_status_in;
   logic [1:0]             out_route_ff, out_route_in;
   logic                   out_ka_ff, out_ka_in;
   logic [31:0]            out_length_ff, out_length_in;
   logic [15:0]            out_body_ff, out_body_in;
   logic [32:0]            out_total_ff, out_total_in;
   logic                   move;
   logic [SUM_W-1:0]       length_wide;
   logic [SUM_W-1:0]       total_wide;

   assign move          = !out_valid_ff || rsp_chan.ready;
   assign snap_free     = !snap_valid_ff || move;
   assign snap_valid_in = snap_load ? 1'b1 : (move ? 1'b0 : snap_valid_ff);
   assign out_valid_in  = move ? snap_valid_ff : out_valid_ff;

   assign length_wide = SUM_W'(snap_length_ff);
   assign total_wide  = length_wide + SUM_W'(snap_ff.body_start);

   always_comb begin
      out_status_in = STATUS_INCOMPLETE;
      out_route_in  = ROUTE_OTHER;
      out_ka_in     = 1'b0;
      out_length_in = '0;
      out_body_in   = '0;
      out_total_in  = '0;
      if (snap_ff.body_phase) begin
         if (snap_ff.error) begin
            out_status_in = STATUS_MALFORMED;
         end else begin
            out_route_in  = snap_ff.route;
            out_ka_in     = snap_ff.persist;
            out_length_in = length_wide[31:0];
            out_body_in   = snap_ff.body_start;
            out_total_in  = total_wide[32:0];
            out_status_in = (SUM_W'(snap_ff.byte_count) < total_wide)
                            ? STATUS_INCOMPLETE : STATUS_COMPLETE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_ff        <= snap;
         snap_length_ff <= snap_length;
      end
      if (move && snap_valid_ff) begin
         out_status_ff <= out_status_in;
         out_route_ff  <= out_route_in;
         out_ka_ff     <= out_ka_in;
         out_length_ff <= out_length_in;
         out_body_ff   <= out_body_in;
         out_total_ff  <= out_total_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.route        = out_route_ff;
   assign rsp_chan.conn_persist = out_ka_ff;
   assign rsp_chan.body_bytes   = out_length_ff;
   assign rsp_chan.body_offset  = out_body_ff;
   assign rsp_chan.need_bytes   = out_total_ff;

   // A held snapshot is never dropped while the output register is blocked.
   a_snap_kept: assert property (@(posedge clock) disable iff (reset)
      (snap_valid_ff && !move) |=> snap_valid_ff)
      else $error("pending verdict lost");

   // A malformed verdict carries no other information.
   a_malformed_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == STATUS_MALFORMED) |->
      (out_route_ff == ROUTE_OTHER && !out_ka_ff && out_length_ff == '0 &&
       out_body_ff == '0 && out_total_ff == '0))
      else $error("malformed verdict with nonzero fields");

   // A complete request always has a body offset past the blank line.
   a_complete_offset: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == STATUS_COMPLETE) |-> out_body_ff != '0)
      else $error("complete verdict without body offset");

endmodule

>>> bench/http_request_header_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser testbench
// Feeds receive buffers one byte per word, with the last flag on the final
// byte. Each accepted byte also goes through a local model of the parser. The
// model's verdicts are queued and compared, field by field, with the words
// that leave the verdict channel. The run covers hand-picked buffers, random
// requests, broken requests and noise. These are sent under several idling
// mixes and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module http_request_header_parser_top_tb;
   import hrhp_pkg::*;

   typedef enum logic [1:0] {SCAN_REQUEST, SCAN_HEADERS, SCAN_BODY} scan_phase_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  route;
      logic        conn_persist;
      logic [31:0] body_bytes;
      logic [15:0] body_offset;
      logic [32:0] need_bytes;
   } verdict_type;

   localparam logic [63:0] LENGTH_LIMIT = (64'd1 << DEFAULT_LENGTH_BITS) - 64'd1;
   localparam int unsigned LINE_FILL_MAX = 32'h1FFFF;

   // Value tracker codes: a length value is blank, digits or bad. A connection
   // value counts the letters of "close" that have matched, then goes bad.
   localparam int unsigned VAL_IDLE   = 0;
   localparam int unsigned VAL_DIGITS = 1;
   localparam int unsigned VAL_BAD    = 2;
   localparam int unsigned CONN_WORD  = 5;
   localparam int unsigned CONN_OTHER = 6;

   logic clock;
   logic reset;

   hrhp_req_if req_if ();
   hrhp_rsp_if rsp_if ();

   http_request_header_parser_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Texts the parser looks for.
   string route_ready_line = "GET /ready HTTP/1.1";
   string route_fraud_line = "POST /fraud-score HTTP/1.1";
   string version_text     = "HTTP/1.1";
   string cl_field         = "content-length:";
   string conn_field       = "connection:";
   string close_text       = "close";
   string crlf             = "\015\012";

   // Words waiting to be driven: {last flag, byte}.
   logic [8:0]  pending_bytes[$];
   verdict_type expected_verdicts[$];
   logic [7:0]  msg[$];

   int send_idle_pct;
   int recv_stall_pct;
   bit hold_rx;

   int error_count;
   int words_taken;
   int buffers_queued;
   int verdicts_seen;
   int n_complete;
   int n_malformed;
   int n_incomplete;

   // -------------------------------------------------------------------------
   // Parser model. One call per accepted byte; state lives at module level.
   // -------------------------------------------------------------------------
   int unsigned    pos_count;
   logic [7:0]     prev_byte;
   scan_phase_type phase;
   int unsigned    line_fill;
   bit             get_alive;
   bit             post_alive;
   int unsigned    space_count;
   int unsigned    tag_count;
   bit             cl_alive;
   bit             conn_alive;
   bit             in_length;
   bit             in_conn;
   int unsigned    value_state;
   logic [63:0]    length_acc;
   logic [63:0]    length_val;
   bit             persist_now;
   bit             malformed;
   logic [1:0]     route_now;
   bit             saw_header;
   int unsigned    body_at;

   function automatic void start_field_line();
      line_fill   = 0;
      cl_alive    = 1'b1;
      conn_alive  = 1'b1;
      in_length   = 1'b0;
      in_conn     = 1'b0;
      value_state = VAL_IDLE;
      length_acc  = '0;
   endfunction

   function automatic void clear_parser();
      pos_count   = 0;
      prev_byte   = 8'h00;
      phase       = SCAN_REQUEST;
      get_alive   = 1'b1;
      post_alive  = 1'b1;
      space_count = 0;
      tag_count   = 0;
      length_val  = '0;
      persist_now = 1'b1;
      malformed   = 1'b0;
      route_now   = ROUTE_OTHER;
      saw_header  = 1'b0;
      body_at     = 0;
      start_field_line();
   endfunction

   function automatic void bump_line();
      if (line_fill < LINE_FILL_MAX) line_fill++;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   // The request line tracks both exact routes and the generic form: after
   // the second space the version text must follow exactly; any miss latches.
   function automatic void scan_request_char(input logic [7:0] c);
      int unsigned p;
      p = line_fill;
      if (p >= route_ready_line.len() || c != 8'(route_ready_line[p])) get_alive = 1'b0;
      if (p >= route_fraud_line.len() || c != 8'(route_fraud_line[p])) post_alive = 1'b0;
      if (c == CH_SPACE) begin
         if (space_count < 3) space_count++;
         if (space_count == 2) tag_count = 0;
      end else if (space_count == 2) begin
         if (tag_count < 8 && c == 8'(version_text[tag_count])) tag_count++;
         else tag_count = 15;
      end
      bump_line();
   endfunction

   function automatic void scan_length_char(input logic [7:0] c);
      bit          digit;
      logic [63:0] d;
      digit = (c >= 8'h30) && (c <= 8'h39);
      d     = digit ? 64'(c - 8'h30) : 64'd0;
      if (value_state == VAL_IDLE) begin
         if (is_blank(c)) return;
         if (digit) begin
            length_acc  = d;
            value_state = VAL_DIGITS;
         end else begin
            value_state = VAL_BAD;
         end
      end else if (value_state == VAL_DIGITS) begin
         // Refuse the digit if the value would pass the length limit.
         if (!digit || length_acc > (LENGTH_LIMIT - d) / 64'd10) value_state = VAL_BAD;
         else length_acc = length_acc * 64'd10 + d;
      end
   endfunction

   function automatic void scan_conn_char(input logic [7:0] lc);
      if (value_state == VAL_IDLE) begin
         if (is_blank(lc)) return;
         value_state = (lc == 8'(close_text[0])) ? 1 : CONN_OTHER;
      end else if (value_state >= 1 && value_state <= 4) begin
         value_state = (lc == 8'(close_text[value_state])) ? value_state + 1 : CONN_OTHER;
      end else begin
         value_state = CONN_OTHER;
      end
   endfunction

   function automatic void scan_header_char(input logic [7:0] c);
      logic [7:0]  lc;
      int unsigned i;
      lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
      i  = line_fill;
      if (in_length) begin
         scan_length_char(c);
      end else if (in_conn) begin
         scan_conn_char(lc);
      end else begin
         if (cl_alive && !(i < cl_field.len() && lc == 8'(cl_field[i]))) cl_alive = 1'b0;
         if (conn_alive && !(i < conn_field.len() && lc == 8'(conn_field[i])))
            conn_alive = 1'b0;
         if (cl_alive && i == cl_field.len() - 1) begin
            in_length  = 1'b1;
            cl_alive   = 1'b0;
            conn_alive = 1'b0;
         end else if (conn_alive && i == conn_field.len() - 1) begin
            in_conn    = 1'b1;
            cl_alive   = 1'b0;
            conn_alive = 1'b0;
         end
      end
      bump_line();
   endfunction

   function automatic void scan_char(input logic [7:0] c);
      if (phase == SCAN_REQUEST) scan_request_char(c);
      else scan_header_char(c);
   endfunction

   function automatic void close_line();
      if (phase == SCAN_REQUEST) begin
         if (get_alive && line_fill == route_ready_line.len()) route_now = ROUTE_READY;
         else if (post_alive && line_fill == route_fraud_line.len()) route_now = ROUTE_FRAUD;
         else if (space_count == 2 && tag_count == 8) route_now = ROUTE_OTHER;
         else malformed = 1'b1;
         phase = SCAN_HEADERS;
         start_field_line();
      end else if (line_fill == 0) begin
         // Blank line: header done. A request without header lines is refused.
         if (!saw_header) malformed = 1'b1;
         body_at = pos_count + 1;
         phase   = SCAN_BODY;
      end else begin
         if (in_length) begin
            if (value_state == VAL_BAD) malformed = 1'b1;
            else length_val = length_acc;
         end else if (in_conn) begin
            if (value_state == CONN_WORD) persist_now = 1'b0;
         end
         saw_header = 1'b1;
         start_field_line();
      end
   endfunction

   // Returns 1 when the byte carries the last flag, with the verdict in v.
   function automatic bit parse_byte(input logic [7:0] c, input logic last,
                                     output verdict_type v);
      logic [63:0] total;
      bit          prev_cr;
      v = '0;
      if (pos_count < BUFFER_CAP_INT) begin
         if (phase != SCAN_BODY) begin
            // A CR waits one byte: with LF it ends the line, else it is content.
            prev_cr = (prev_byte == CH_CR);
            if (prev_cr && c == CH_LF) begin
               close_line();
            end else begin
               if (prev_cr) scan_char(CH_CR);
               if (c != CH_CR) scan_char(c);
            end
         end
         prev_byte = c;
         pos_count++;
      end
      if (!last) return 1'b0;
      if (phase == SCAN_BODY) begin
         if (malformed) begin
            v.status = STATUS_MALFORMED;
         end else begin
            total          = 64'(body_at) + length_val;
            v.route        = route_now;
            v.conn_persist = persist_now;
            v.body_bytes   = length_val[31:0];
            v.body_offset  = body_at[15:0];
            v.need_bytes   = total[32:0];
            v.status       = (64'(pos_count) < total) ? STATUS_INCOMPLETE : STATUS_COMPLETE;
         end
      end
      clear_parser();
      return 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // Request side. A word that was taken at this edge goes through the model;
   // then the next word is put up, or valid drops to idle the channel.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : byte_driver
      logic [8:0]  next_word;
      verdict_type v;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.data_byte <= 8'h00;
         req_if.last_byte <= 1'b0;
         clear_parser();
      end else begin
         if (req_if.valid && req_if.ready) begin
            words_taken++;
            if (parse_byte(req_if.data_byte, req_if.last_byte, v))
               expected_verdicts.push_back(v);
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word         = pending_bytes.pop_front();
               req_if.valid     <= 1'b1;
               req_if.data_byte <= next_word[7:0];
               req_if.last_byte <= next_word[8];
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result side. Each verdict taken is checked against the oldest one that
   // the model produced. Ready stalls at random, or stays low for a hold-off.
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH at verdict %0d: %s got %0d, expected %0d",
               verdicts_seen, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : verdict_monitor
      verdict_type got;
      verdict_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{status: rsp_if.status, route: rsp_if.route,
                    conn_persist: rsp_if.conn_persist, body_bytes: rsp_if.body_bytes,
                    body_offset: rsp_if.body_offset, need_bytes: rsp_if.need_bytes};
            if (expected_verdicts.size() == 0) begin
               report_mismatch("verdict with none expected, status", got.status, 0);
            end else begin
               want = expected_verdicts.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.route !== want.route)
                  report_mismatch("route", got.route, want.route);
               if (got.conn_persist !== want.conn_persist)
                  report_mismatch("conn_persist", got.conn_persist, want.conn_persist);
               if (got.body_bytes !== want.body_bytes)
                  report_mismatch("body_bytes", got.body_bytes, want.body_bytes);
               if (got.body_offset !== want.body_offset)
                  report_mismatch("body_offset", got.body_offset, want.body_offset);
               if (got.need_bytes !== want.need_bytes)
                  report_mismatch("need_bytes", got.need_bytes, want.need_bytes);
               case (want.status)
                  STATUS_COMPLETE:  n_complete++;
                  STATUS_MALFORMED: n_malformed++;
                  default:          n_incomplete++;
               endcase
            end
            verdicts_seen++;
         end
         rsp_if.ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Buffer building. Bytes collect in msg; send_msg moves them to the driver
   // queue with the last flag on the final byte.
   // -------------------------------------------------------------------------
   task automatic append_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) msg.push_back(8'(s[i]));
   endtask

   // Letters come out in random case.
   task automatic append_mixed(input string s);
      int         i;
      logic [7:0] ch;
      for (i = 0; i < s.len(); i++) begin
         ch = 8'(s[i]);
         if (((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) &&
             $urandom_range(1) == 1)
            ch = ch ^ 8'h20;
         msg.push_back(ch);
      end
   endtask

   task automatic append_token(input int n, input bit upper);
      repeat (n) msg.push_back((upper ? 8'h41 : 8'h61) + 8'($urandom_range(25)));
   endtask

   task automatic append_digits(input int n);
      repeat (n) msg.push_back(8'h30 + 8'($urandom_range(9)));
   endtask

   task automatic append_blanks();
      repeat ($urandom_range(2)) msg.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
   endtask

   task automatic send_msg();
      int i;
      for (i = 0; i < msg.size(); i++) pending_bytes.push_back({i == msg.size() - 1, msg[i]});
      msg.delete();
      buffers_queued++;
   endtask

   task automatic append_header();
      case ($urandom_range(5))
         0, 1: begin
            append_mixed("Content-Length:");
            append_blanks();
            case ($urandom_range(7))
               0, 1, 2, 3: append_text($sformatf("%0d", $urandom_range(30)));
               4: append_text($sformatf("%0d", $urandom()));
               5: append_digits($urandom_range(10, 11));
               6: begin
                  append_digits($urandom_range(2));
                  append_token(1, 1'b0);
               end
               default: append_text("12 ");
            endcase
         end
         2, 3: begin
            append_mixed("Connection:");
            append_blanks();
            case ($urandom_range(5))
               0, 1: append_mixed("close");
               2: append_text("keep-alive");
               3: begin
                  append_mixed("close");
                  append_token(1, 1'b0);
               end
               4: append_text("clos");
               default: ;
            endcase
         end
         4: begin
            // Names that share a prefix with the tracked ones.
            append_mixed($urandom_range(1) ? "Content-" : "Conn");
            append_token($urandom_range(1, 5), 1'b0);
            append_text(": 5");
         end
         default: begin
            append_token($urandom_range(1, 8), 1'b1);
            append_text(": ");
            append_token($urandom_range(12), 1'b0);
         end
      endcase
   endtask

   task automatic append_request();
      int n_fields;
      case ($urandom_range(9))
         0, 1: append_text(route_ready_line);
         2, 3: append_text(route_fraud_line);
         4, 5, 6: begin
            append_token($urandom_range(1, 7), 1'b1);
            append_text(" /");
            append_token($urandom_range(10), 1'b0);
            append_text(" HTTP/1.1");
         end
         7: append_text($urandom_range(1) ? "GET /ready HTTP/1.1 " : "GET /readyx HTTP/1.1");
         8: append_text($sformatf("POST /fraud-score HTTP/1.%0d", $urandom_range(1)));
         default: begin
            append_token($urandom_range(1, 4), 1'b1);
            append_text(" HTTP/1.1");
         end
      endcase
      append_text(crlf);
      n_fields = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4);
      repeat (n_fields) begin
         append_header();
         append_text(crlf);
      end
      append_text(crlf);
      repeat ($urandom_range(20)) msg.push_back(8'($urandom_range(255)));
   endtask

   task automatic append_noise(input int n);
      logic [7:0] b;
      repeat (n) begin
         b = 8'($urandom_range(255));
         case ($urandom_range(7))
            0: b = CH_CR;
            1: b = CH_LF;
            default: ;
         endcase
         msg.push_back(b);
      end
   endtask

   // Mostly well-formed requests with random content; the rest are cut short,
   // have one or two bytes overwritten, or are plain noise.
   task automatic queue_random(input int byte_goal, input int buffer_goal);
      int queued;
      int buffers;
      int k;
      queued  = 0;
      buffers = 0;
      while (queued < byte_goal || buffers < buffer_goal) begin
         case ($urandom_range(9))
            7: begin
               append_request();
               k = $urandom_range(1, msg.size());
               while (msg.size() > k) void'(msg.pop_back());
            end
            8: begin
               append_request();
               repeat ($urandom_range(1, 2))
                  msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
            end
            9: append_noise($urandom_range(1, 24));
            default: append_request();
         endcase
         queued += msg.size();
         buffers++;
         send_msg();
      end
   endtask

   task automatic queue_directed();
      // Both known routes, one with a length, a close and a full body.
      append_text({route_ready_line, crlf, "Host: a", crlf, crlf});
      send_msg();
      append_text({route_fraud_line, crlf, "Content-Length: 5", crlf, "Connection: close",
                   crlf, crlf, "hello"});
      send_msg();
      // Body short of the length: fields are still reported.
      append_text({route_fraud_line, crlf, "Content-Length: 5", crlf, crlf, "hel"});
      send_msg();
      // Largest length, upper case name, tab and space before the value.
      append_text({"PUT /x HTTP/1.1", crlf, "CONTENT-LENGTH:\t 4294967295", crlf, crlf});
      send_msg();
      // One past the largest length.
      append_text({route_ready_line, crlf, "content-length: 4294967296", crlf, crlf});
      send_msg();
      // The last length line wins even when empty; mixed case close.
      append_text({"A / HTTP/1.1", crlf, "Content-Length: 7", crlf, "Content-Length:", crlf,
                   "cOnNeCtIoN:  \tClOsE", crlf, crlf});
      send_msg();
      // No header lines at all.
      append_text({route_ready_line, crlf, crlf});
      send_msg();
      // Wrong version, then a request line with three spaces.
      append_text({"GET / HTTP/1.0", crlf, "A: b", crlf, crlf});
      send_msg();
      append_text({"GET  / HTTP/1.1", crlf, "A: b", crlf, crlf});
      send_msg();
      // Lone CR, lone LF, CR CR LF and the byte extremes inside header lines.
      append_text({"X /y HTTP/1.1", crlf, "K: a\015b\012c"});
      msg.push_back(8'h00);
      msg.push_back(8'hFF);
      msg.push_back(8'h80);
      append_text({crlf, "\015\015\012", crlf, "z"});
      send_msg();
      // Cut off inside the request line, and one-byte buffers.
      append_text("GET /ready HT");
      send_msg();
      msg.push_back(8'hFF);
      send_msg();
      msg.push_back(8'h00);
      send_msg();
      // A bad length before the blank line is not yet reported.
      append_text({route_ready_line, crlf, "Content-Length: 1x", crlf});
      send_msg();
      append_text({route_fraud_line, crlf, "Content-Length: 12a", crlf, crlf});
      send_msg();
      // Values that must not clear keep-alive.
      append_text({route_fraud_line, crlf, "Connection: closed", crlf, "Connection: keep-alive",
                   crlf, crlf});
      send_msg();
      // Extra text after a route prefix gives a generic route.
      append_text({"GET /readyx HTTP/1.1", crlf, "Host: b", crlf, crlf});
      send_msg();
      // Line breaks in the body are not parsed; extra body bytes are fine.
      append_text({"GET /q HTTP/1.1", crlf, "Content-Length: 2", crlf, crlf, crlf, crlf, "xyz"});
      send_msg();
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_if.valid || expected_verdicts.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.last_byte = 1'b0;
      rsp_if.ready     = 1'b0;
      reset            = 1'b1;
      clock            = 1'b0;
      hold_rx          = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      error_count      = 0;
      words_taken      = 0;
      buffers_queued   = 0;
      verdicts_seen    = 0;
      n_complete       = 0;
      n_malformed      = 0;
      n_incomplete     = 0;
      clear_parser();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Hand-picked buffers and random ones, both sides always ready.
      queue_directed();
      wait_drained();
      queue_random(180, 2);
      wait_drained();

      // Random traffic under the idling mixes; the sender waits for every
      // verdict before the next mix starts.
      send_idle_pct = 45;
      queue_random(180, 2);
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 45;
      queue_random(180, 2);
      wait_drained();
      send_idle_pct  = 24;
      recv_stall_pct = 24;
      queue_random(180, 2);
      wait_drained();

      // Long hold-off on the result side while short buffers keep coming:
      // the verdict stages fill and the request side must stall.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_rx = 1'b1;
            repeat (400) @(negedge clock);
            hold_rx = 1'b0;
         end
         begin
            repeat (20) begin
               append_noise(1);
               send_msg();
            end
            repeat (3) begin
               append_request();
               send_msg();
            end
         end
      join
      wait_drained();

      // Room for a verdict still in the pipeline that nothing predicted.
      repeat (8) @(negedge clock);
      $display("Run took %0d bytes in %0d buffers and checked %0d verdicts", words_taken,
               buffers_queued, verdicts_seen);
      $display("(%0d complete, %0d malformed, %0d incomplete), idling mixes and a hold-off.",
               n_complete, n_malformed, n_incomplete);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, far above the slowest correct run.
   initial begin : watchdog
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
